// ===== src/net_pkg.sv =====
// Shared types and constants for the explosion and thrust noise voice block.
// Holds the micro-op encoding, the control word layout and the volume table.
// No dependencies.
`timescale 1ns / 1ps

package net_pkg;

    // Sample rate register and its effective range.
    localparam int RATE_W = 18;
    localparam logic [RATE_W-1:0] RATE_MIN = 18'd1025;
    localparam logic [RATE_W-1:0] RATE_MAX = 18'd192000;

    // Phase accumulators are signed and span -12000 up to the largest rate.
    localparam int PHASE_W = 19;
    localparam logic signed [PHASE_W-1:0] NOISE_HZ  = 19'sd12000;
    localparam logic signed [PHASE_W-1:0] THRUST_HZ = 19'sd110;

    // Thrust level and the serial divider that scales its update.
    localparam int LEVEL_W = 15;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd32767;
    localparam int DIVIDEND_W = LEVEL_W + 10;
    localparam int QUOT_W = 15;
    localparam int DIV_CNT_W = 4;

    // Output sample width.
    localparam int SAMPLE_W = 15;

    // Micro-op step counter width.
    localparam int STEP_W = 4;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_WAIT,
        OP_NSUB,
        OP_NLOOP,
        OP_TSUB,
        OP_TLOOP,
        OP_DSETUP,
        OP_DWAIT,
        OP_DAPPLY,
        OP_OUT,
        OP_NOP
    } op_t;

    // How the step counter moves after a step.
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_JUMP,
        COND_IF_FLAG,
        COND_IF_NOT_FLAG
    } cond_t;

    // One control word of the micro-program.
    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Resistor-divider volume levels indexed by latch bits 2 to 5.
    localparam logic [LEVEL_W-1:0] VOLUME_TABLE [16] = '{
        15'd0,     15'd2121,  15'd4532,  15'd6653,
        15'd8308,  15'd10430, 15'd12840, 15'd14962,
        15'd17804, 15'd19926, 15'd22336, 15'd24458,
        15'd26113, 15'd28234, 15'd30645, 15'd32767
    };

endpackage

// ===== src/net_sequencer.sv =====
// Micro-program sequencer: step counter, control store and conditional jumps.
// Depends on net_pkg for the control word layout.
`timescale 1ns / 1ps

module net_sequencer import net_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   flag,
    output ucode_t uword
);

    localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_NLOOP = 4'd2;
    localparam logic [STEP_W-1:0] STEP_TLOOP = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DWAIT = 4'd6;
    localparam logic [STEP_W-1:0] STEP_OUT   = 4'd8;
    localparam logic [STEP_W-1:0] NUM_STEPS  = 4'd10;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;

    // Control store: one word per step.
    always_comb begin
        case (pc_reg)
            4'd0:    uword = '{op: OP_WAIT,   cond: COND_IF_NOT_FLAG, target: STEP_WAIT};
            4'd1:    uword = '{op: OP_NSUB,   cond: COND_NEXT,        target: STEP_WAIT};
            4'd2:    uword = '{op: OP_NLOOP,  cond: COND_IF_FLAG,     target: STEP_NLOOP};
            4'd3:    uword = '{op: OP_TSUB,   cond: COND_IF_FLAG,     target: STEP_OUT};
            4'd4:    uword = '{op: OP_TLOOP,  cond: COND_IF_FLAG,     target: STEP_TLOOP};
            4'd5:    uword = '{op: OP_DSETUP, cond: COND_IF_FLAG,     target: STEP_OUT};
            4'd6:    uword = '{op: OP_DWAIT,  cond: COND_IF_FLAG,     target: STEP_DWAIT};
            4'd7:    uword = '{op: OP_DAPPLY, cond: COND_NEXT,        target: STEP_WAIT};
            4'd8:    uword = '{op: OP_OUT,    cond: COND_IF_FLAG,     target: STEP_OUT};
            4'd9:    uword = '{op: OP_NOP,    cond: COND_JUMP,        target: STEP_WAIT};
            default: uword = '{op: OP_NOP,    cond: COND_JUMP,        target: STEP_WAIT};
        endcase
    end

    // Next step from the jump condition and the datapath flag.
    always_comb begin
        case (uword.cond)
            COND_NEXT:        pc_next = pc_reg + 4'd1;
            COND_JUMP:        pc_next = uword.target;
            COND_IF_FLAG:     pc_next = flag ? uword.target : pc_reg + 4'd1;
            COND_IF_NOT_FLAG: pc_next = flag ? pc_reg + 4'd1 : uword.target;
            default:          pc_next = STEP_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

`ifndef SYNTH
    // The step counter never leaves the program.
    assert property (@(posedge aclk) disable iff (!aresetn) pc_reg < NUM_STEPS)
        else $error("step counter outside the micro-program");
`endif

endmodule

// ===== src/net_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, for the thrust update.
// Depends on net_pkg for widths. The quotient is known to fit in 15 bits.
`timescale 1ns / 1ps

module net_divider import net_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [RATE_W-1:0]     divisor,
    output logic                  busy,
    output logic [QUOT_W-1:0]     quotient
);

    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_CNT_W-1:0] count_next;
    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    rem_next;
    logic [QUOT_W-1:0]    shift_reg;
    logic [QUOT_W-1:0]    shift_next;
    logic [RATE_W-1:0]    div_reg;
    logic [RATE_W-1:0]    div_next;
    logic [RATE_W:0]      trial;
    logic                 fits;

    // One shift-and-subtract step; the quotient bit enters at the bottom.
    assign trial = {rem_reg, shift_reg[QUOT_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        count_next = count_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        if (start) begin
            // Upper dividend bits are below the divisor, so they seed the remainder.
            count_next = DIV_CNT_W'(QUOT_W);
            rem_next   = RATE_W'(dividend[DIVIDEND_W-1:QUOT_W]);
            shift_next = dividend[QUOT_W-1:0];
            div_next   = divisor;
        end else if (count_reg != '0) begin
            count_next = count_reg - DIV_CNT_W'(1);
            rem_next   = fits ? RATE_W'(trial - {1'b0, div_reg}) : trial[RATE_W-1:0];
            shift_next = {shift_reg[QUOT_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        div_reg   <= div_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = shift_reg;

`ifndef SYNTH
    // The partial remainder stays below the divisor while a division runs.
    assert property (@(posedge aclk) disable iff (!aresetn) busy |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== src/net_datapath.sv =====
// Voice datapath: noise register, pitch counter, phase accumulators, thrust level
// and the output register. Driven by control words from net_sequencer; uses
// net_divider and net_pkg.
`timescale 1ns / 1ps

module net_datapath import net_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  ucode_t              uword,
    input  logic [RATE_W-1:0]   rate,
    output logic                flag,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_explosion_control,
    input  logic                s_thrust_on,
    input  logic                s_last_in_buffer,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_mixed_sample,
    output logic                m_buffer_end
);

    logic signed [PHASE_W-1:0] noise_phase_reg, noise_phase_next;
    logic [LEVEL_W-1:0]        noise_reg, noise_next;
    logic [3:0]                pitch_reg, pitch_next;
    logic                      gate_reg, gate_next;
    logic signed [PHASE_W-1:0] thrust_phase_reg, thrust_phase_next;
    logic                      tnoise_reg, tnoise_next;
    logic [LEVEL_W-1:0]        level_reg, level_next;
    logic [7:0]                ctl_reg, ctl_next;
    logic                      on_reg, on_next;
    logic                      last_reg, last_next;
    logic                      m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]       m_sample_reg, m_sample_next;
    logic                      m_end_reg, m_end_next;

    logic signed [PHASE_W-1:0] rate_s;
    logic                      feedback;
    logic [LEVEL_W-1:0]        shifted;
    logic [3:0]                pitch_inc;
    logic [3:0]                pitch_load;
    logic [LEVEL_W-1:0]        div_operand;
    logic                      div_start;
    logic                      div_busy;
    logic [QUOT_W-1:0]         quotient;
    logic [LEVEL_W:0]          step_size;
    logic [LEVEL_W:0]          charged;
    logic [LEVEL_W-1:0]        explosion;
    logic [LEVEL_W-1:0]        thrust;
    logic                      out_busy;

    assign rate_s = $signed({1'b0, rate});

    // Noise step: feedback from bits 14 and 6, pitch advance with reload at 16.
    assign feedback   = (noise_reg[14] == noise_reg[6]);
    assign shifted    = {noise_reg[LEVEL_W-2:0], feedback};
    assign pitch_inc  = pitch_reg + 4'd1;
    assign pitch_load = (ctl_reg[6] ? 4'd10 : 4'd4) | (ctl_reg[7] ? 4'd9 : 4'd0);

    // Thrust update operand and step size from the divider.
    assign div_operand = tnoise_reg ? (LEVEL_MAX - level_reg) : level_reg;
    assign step_size   = {1'b0, quotient} + 16'd1;
    assign charged     = {1'b0, level_reg} + step_size;

    // Output mix.
    assign explosion = gate_reg ? VOLUME_TABLE[ctl_reg[5:2]] : '0;
    assign thrust    = on_reg ? level_reg : '0;
    assign out_busy  = m_valid_reg && !m_ready;

    assign s_ready = (uword.op == OP_WAIT);

    // Per-step operation and condition flag.
    always_comb begin
        noise_phase_next  = noise_phase_reg;
        noise_next        = noise_reg;
        pitch_next        = pitch_reg;
        gate_next         = gate_reg;
        thrust_phase_next = thrust_phase_reg;
        tnoise_next       = tnoise_reg;
        level_next        = level_reg;
        ctl_next          = ctl_reg;
        on_next           = on_reg;
        last_next         = last_reg;
        m_sample_next     = m_sample_reg;
        m_end_next        = m_end_reg;
        m_valid_next      = m_ready ? 1'b0 : m_valid_reg;
        div_start         = 1'b0;
        flag              = 1'b0;
        case (uword.op)
            OP_WAIT: begin
                flag = s_valid;
                if (s_valid) begin
                    ctl_next  = s_explosion_control;
                    on_next   = s_thrust_on;
                    last_next = s_last_in_buffer;
                end
            end
            OP_NSUB: begin
                noise_phase_next = noise_phase_reg - NOISE_HZ;
            end
            OP_NLOOP: begin
                flag = (noise_phase_reg <= 19'sd0);
                if (flag) begin
                    noise_phase_next = noise_phase_reg + rate_s;
                    noise_next       = shifted;
                    pitch_next       = (pitch_inc == 4'd0) ? pitch_load : pitch_inc;
                    if (pitch_next == 4'd15) begin
                        gate_next = shifted[0];
                    end
                end
            end
            OP_TSUB: begin
                flag = !on_reg;
                if (on_reg) begin
                    thrust_phase_next = thrust_phase_reg - THRUST_HZ;
                end
            end
            OP_TLOOP: begin
                flag = (thrust_phase_reg <= 19'sd0);
                if (flag) begin
                    thrust_phase_next = thrust_phase_reg + rate_s;
                    tnoise_next       = noise_reg[0];
                end
            end
            OP_DSETUP: begin
                // A full level does not charge and an empty one does not discharge.
                flag      = tnoise_reg ? (level_reg == LEVEL_MAX) : (level_reg == '0);
                div_start = !flag;
            end
            OP_DWAIT: begin
                flag = div_busy;
            end
            OP_DAPPLY: begin
                if (tnoise_reg) begin
                    level_next = (charged > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                              : charged[LEVEL_W-1:0];
                end else begin
                    level_next = (step_size > {1'b0, level_reg}) ? '0
                                 : LEVEL_W'({1'b0, level_reg} - step_size);
                end
            end
            OP_OUT: begin
                flag = out_busy;
                if (!out_busy) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = {1'b0, explosion[LEVEL_W-1:1]}
                                  + {1'b0, thrust[LEVEL_W-1:1]};
                    m_end_next    = last_reg;
                end
            end
            OP_NOP: begin
                flag = 1'b0;
            end
            default: begin
                flag = 1'b0;
            end
        endcase
    end

    // Serial divider: operand * 1024 / rate.
    net_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({div_operand, 10'd0}),
        .divisor  (rate),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_phase_reg  <= '0;
            noise_reg        <= '0;
            pitch_reg        <= '0;
            gate_reg         <= 1'b0;
            thrust_phase_reg <= '0;
            tnoise_reg       <= 1'b0;
            level_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            noise_phase_reg  <= noise_phase_next;
            noise_reg        <= noise_next;
            pitch_reg        <= pitch_next;
            gate_reg         <= gate_next;
            thrust_phase_reg <= thrust_phase_next;
            tnoise_reg       <= tnoise_next;
            level_reg        <= level_next;
            m_valid_reg      <= m_valid_next;
        end
        ctl_reg      <= ctl_next;
        on_reg       <= on_next;
        last_reg     <= last_next;
        m_sample_reg <= m_sample_next;
        m_end_reg    <= m_end_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_mixed_sample = m_sample_reg;
    assign m_buffer_end   = m_end_reg;

`ifndef SYNTH
    // The level is only applied once the division has finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == OP_DAPPLY) |-> !div_busy)
        else $error("thrust update applied while divider busy");
    // Noise stepping leaves a positive phase behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == OP_TSUB) |-> (noise_phase_reg > 19'sd0))
        else $error("noise phase not positive after stepping");
    // The thrust phase is positive by the time the level update starts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == OP_DSETUP) |-> (thrust_phase_reg > 19'sd0))
        else $error("thrust phase not positive before level update");
`endif

endmodule

// ===== src/noise_explosion_thrust_voice_core.sv =====
// Top level of the explosion and thrust noise voice block: APB register,
// rate clamp, micro-program sequencer and voice datapath.
// Depends on net_pkg, net_sequencer, net_datapath and net_divider.
// Per sample: noise step loop, thrust phase step, level update on the serial divider,
// then the output register; thrust off or a level at rest skips to the output.
// A new input is taken only after the previous result is loaded; the noise step loop,
// the divider wait and a result still held at the output all lengthen the gap.
// Reset: synchronous, active low; clears the noise, phase, level and output valid state and sets the rate to 44100 Hz.
`timescale 1ns / 1ps

module noise_explosion_thrust_voice_core import net_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_explosion_control,
    input  logic                s_thrust_on,
    input  logic                s_last_in_buffer,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_mixed_sample,
    output logic                m_buffer_end
);

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

    logic [RATE_W-1:0] rate_cfg_reg;
    logic [RATE_W-1:0] rate_cfg_next;
    logic [RATE_W-1:0] eff_rate;
    logic              reg_hit;
    ucode_t            uword;
    logic              flag;

    // Register decode: the rate register answers at byte addresses 0 to 3.
    assign reg_hit = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(32 - RATE_W){1'b0}}, rate_cfg_reg} : 32'd0;

    always_comb begin
        rate_cfg_next = rate_cfg_reg;
        if (psel && penable && pwrite && reg_hit) begin
            rate_cfg_next = pwdata[RATE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_cfg_reg <= RATE_RESET;
        end else begin
            rate_cfg_reg <= rate_cfg_next;
        end
    end

    // Effective rate is the register clamped to the supported range.
    assign eff_rate = (rate_cfg_reg < RATE_MIN) ? RATE_MIN
                    : (rate_cfg_reg > RATE_MAX) ? RATE_MAX : rate_cfg_reg;

    net_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flag    (flag),
        .uword   (uword)
    );

    net_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .uword               (uword),
        .rate                (eff_rate),
        .flag                (flag),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_explosion_control (s_explosion_control),
        .s_thrust_on         (s_thrust_on),
        .s_last_in_buffer    (s_last_in_buffer),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_mixed_sample      (m_mixed_sample),
        .m_buffer_end        (m_buffer_end)
    );

endmodule
